// ===== rtl/core/lps_pkg.sv =====
package lps_pkg;

    localparam int LPS_MAX_LEDS   = 16;
    localparam int LPS_MODE_W     = 3;
    localparam int LPS_COUNT_W    = 5;
    localparam int LPS_CFG_IDX_W  = 2;
    localparam int LPS_CFG_DATA_W = 5;
    localparam int LPS_LEDS_W     = 16;
    localparam int LPS_TICK_W     = 3;
    localparam int LPS_STEP_W     = 5;
    localparam int LPS_ELEM_W     = LPS_STEP_W - 1;

    // register indexes
    localparam logic [LPS_CFG_IDX_W-1:0] LPS_CFG_MODE  = 2'd0;
    localparam logic [LPS_CFG_IDX_W-1:0] LPS_CFG_COUNT = 2'd1;

    // pattern modes
    localparam logic [LPS_MODE_W-1:0] LPS_MODE_FILL   = 3'd0;
    localparam logic [LPS_MODE_W-1:0] LPS_MODE_RUNNER = 3'd1;
    localparam logic [LPS_MODE_W-1:0] LPS_MODE_ALT    = 3'd2;
    localparam logic [LPS_MODE_W-1:0] LPS_MODE_SOS    = 3'd3;
    localparam logic [LPS_MODE_W-1:0] LPS_MODE_BLINK  = 3'd4;

    localparam logic [LPS_MODE_W-1:0]  LPS_MODE_RST  = LPS_MODE_FILL;
    localparam logic [LPS_COUNT_W-1:0] LPS_COUNT_RST = 5'd16;

    // tick counts
    localparam logic [LPS_TICK_W-1:0] LPS_STEP_TICKS  = 3'd2;
    localparam logic [LPS_TICK_W-1:0] LPS_SLOW_TICKS  = 3'd5;
    localparam logic [LPS_TICK_W-1:0] LPS_DOT_TICKS   = 3'd3;
    localparam logic [LPS_TICK_W-1:0] LPS_DASH_TICKS  = 3'd7;
    localparam logic [LPS_TICK_W-1:0] LPS_ELEM_GAP    = 3'd1;
    localparam logic [LPS_TICK_W-1:0] LPS_CHAR_GAP    = 3'd2;
    localparam logic [LPS_TICK_W-1:0] LPS_WORD_GAP    = 3'd6;

    // morse element numbers: three dots, three dashes, three dots
    localparam logic [LPS_ELEM_W-1:0] LPS_ELEM_DASH_LO = 4'd3;
    localparam logic [LPS_ELEM_W-1:0] LPS_ELEM_DASH_HI = 4'd5;
    localparam logic [LPS_ELEM_W-1:0] LPS_ELEM_CHAR_A  = 4'd2;
    localparam logic [LPS_ELEM_W-1:0] LPS_ELEM_CHAR_B  = 4'd5;
    localparam logic [LPS_ELEM_W-1:0] LPS_ELEM_LAST    = 4'd8;
    localparam logic [LPS_STEP_W-1:0] LPS_STEP_MAX     = 5'd17;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARM   = 2'd1,
        PH_RUN   = 2'd2,
        PH_DRAIN = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LPS_MODE_W-1:0]  mode;
        logic [LPS_COUNT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        logic                  busy;
        logic [LPS_LEDS_W-1:0] leds;
    } t_result;

endpackage

// ===== rtl/core/lps_cfg_regs.sv =====
module lps_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lps_pkg::LPS_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lps_pkg::LPS_CFG_DATA_W-1:0]  i_cfg_data,
    output lps_pkg::t_cfg                       o_cfg
);
    import lps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                LPS_CFG_MODE:  n_cfg.mode  = i_cfg_data[LPS_MODE_W-1:0];
                LPS_CFG_COUNT: n_cfg.count = i_cfg_data[LPS_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= LPS_MODE_RST;
            r_cfg.count <= LPS_COUNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/lps_core.sv =====
module lps_core #(
    parameter int MAX_LEDS = lps_pkg::LPS_MAX_LEDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic              i_cancel,
    input  lps_pkg::t_cfg     i_cfg,
    output lps_pkg::t_result  o_result
);
    import lps_pkg::*;

    localparam int PW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW0 = $clog2(MAX_LEDS + 1);
    localparam int NW  = (CW0 > LPS_COUNT_W) ? CW0 : LPS_COUNT_W;

    t_phase                r_phase, n_phase;
    logic [MAX_LEDS-1:0]   r_bits, n_bits;
    logic [PW-1:0]         r_pos, n_pos;
    logic [LPS_TICK_W-1:0] r_tick, n_tick;
    logic [LPS_STEP_W-1:0] r_step, n_step;
    logic                  r_par, n_par;

    logic [NW-1:0]         cnt_raw, cnt;
    logic [MAX_LEDS-1:0]   mask, alt_mask, top_bit;
    logic [LPS_MODE_W-1:0] md;
    logic [LPS_TICK_W-1:0] tick_inc;
    logic [LPS_TICK_W-1:0] on_len, gap_len;
    logic [LPS_ELEM_W-1:0] elem;
    logic                  last_elem;
    logic                  start_go, run_go;
    logic [NW-1:0]         pos_inc;
    logic [PW-1:0]         pos_nx, pos_prev;

    function automatic logic [MAX_LEDS-1:0] f_bit(input logic [PW-1:0] idx);
        logic [MAX_LEDS-1:0] v;
        for (int i = 0; i < MAX_LEDS; i++) begin
            v[i] = (PW'(i) == idx);
        end
        return v;
    endfunction

    always_comb begin
        cnt_raw = NW'(i_cfg.count);
        cnt     = (cnt_raw > NW'(MAX_LEDS)) ? NW'(MAX_LEDS) : cnt_raw;
        md      = (i_cfg.mode > LPS_MODE_BLINK) ? LPS_MODE_BLINK : i_cfg.mode;
        for (int i = 0; i < MAX_LEDS; i++) begin
            mask[i]     = (NW'(i) < cnt);
            alt_mask[i] = ((i % 2) == 0);
        end
        top_bit   = f_bit(PW'(cnt - NW'(1)));
        tick_inc  = r_tick + LPS_TICK_W'(1);
        elem      = r_step[LPS_STEP_W-1:1];
        last_elem = (elem >= LPS_ELEM_LAST);
        on_len    = (elem >= LPS_ELEM_DASH_LO && elem <= LPS_ELEM_DASH_HI)
                    ? LPS_DASH_TICKS : LPS_DOT_TICKS;
        gap_len   = last_elem ? LPS_WORD_GAP
                  : ((elem == LPS_ELEM_CHAR_A || elem == LPS_ELEM_CHAR_B)
                     ? LPS_CHAR_GAP : LPS_ELEM_GAP);
        pos_inc   = NW'(r_pos) + NW'(1);
        pos_nx    = (pos_inc >= cnt) ? '0 : PW'(pos_inc);
        pos_prev  = (pos_nx == '0) ? PW'(cnt - NW'(1)) : pos_nx - PW'(1);
    end

    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_pos    = r_pos;
        n_tick   = r_tick;
        n_step   = r_step;
        n_par    = r_par;
        start_go = 1'b0;
        run_go   = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_req_type) begin
                    if (i_cancel) n_phase = PH_ARM;
                    else          start_go = 1'b1;
                end
            end
            PH_ARM: begin
                if (!i_cancel) start_go = 1'b1;
            end
            PH_RUN: begin
                if (!i_req_type) run_go = 1'b1;
            end
            PH_DRAIN: begin
                if (!i_cancel) begin
                    n_bits  = '0;
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                    n_tick  = '0;
                    n_step  = '0;
                    n_par   = 1'b0;
                end
            end
        endcase

        if (start_go) begin
            n_phase = PH_RUN;
            n_pos   = '0;
            n_tick  = '0;
            n_step  = '0;
            n_par   = 1'b0;
            if (cnt != '0) begin
                case (md)
                    LPS_MODE_FILL: n_bits = r_bits ^ MAX_LEDS'(1);
                    LPS_MODE_RUNNER: n_bits = ((r_bits | top_bit) ^ MAX_LEDS'(1)) ^ top_bit;
                    LPS_MODE_ALT: begin
                        n_bits = (r_bits ^ (alt_mask & mask)) ^ mask;
                        n_par  = 1'b1;
                    end
                    LPS_MODE_SOS: n_bits = r_bits | mask;
                    default:      n_bits = r_bits ^ mask;
                endcase
            end
        end

        if (run_go) begin
            if ((cnt == '0 || md != LPS_MODE_SOS) && i_cancel) begin
                n_phase = PH_DRAIN;
            end else if (cnt != '0) begin
                n_tick = tick_inc;
                if (md == LPS_MODE_SOS) begin
                    if (!r_step[0]) begin
                        // lit part of a dot or dash
                        if (tick_inc >= on_len) begin
                            if (i_cancel) begin
                                n_phase = PH_DRAIN;
                            end else begin
                                n_bits = r_bits & ~mask;
                                n_step = r_step + LPS_STEP_W'(1);
                                n_tick = '0;
                            end
                        end
                    end else if (tick_inc >= gap_len) begin
                        n_tick = '0;
                        if (last_elem && i_cancel) begin
                            n_phase = PH_DRAIN;
                        end else begin
                            n_step = last_elem ? '0 : r_step + LPS_STEP_W'(1);
                            n_bits = r_bits | mask;
                            if (i_cancel) n_phase = PH_DRAIN;
                        end
                    end
                end else if (md == LPS_MODE_FILL || md == LPS_MODE_RUNNER) begin
                    if (tick_inc >= LPS_STEP_TICKS) begin
                        n_tick = '0;
                        n_pos  = pos_nx;
                        if (md == LPS_MODE_RUNNER) n_bits = r_bits ^ f_bit(pos_nx) ^ f_bit(pos_prev);
                        else                       n_bits = r_bits ^ f_bit(pos_nx);
                    end
                end else if (tick_inc >= LPS_SLOW_TICKS) begin
                    n_tick = '0;
                    n_bits = r_bits ^ mask;
                    if (md == LPS_MODE_ALT) n_par = ~r_par;
                end
            end
        end
    end

    assign o_result.leds = LPS_LEDS_W'(n_bits);
    assign o_result.busy = (n_phase != PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_pos   <= '0;
            r_tick  <= '0;
            r_step  <= '0;
            r_par   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_pos   <= n_pos;
            r_tick  <= n_tick;
            r_step  <= n_step;
            r_par   <= n_par;
        end
    end

    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bits == '0))
        else $error("leds lit while idle");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LPS_STEP_MAX)
        else $error("morse step past end of word");

    a_hold_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_bits) && $stable(r_phase))
        else $error("state moved without a request");

endmodule

// ===== rtl/core/lps_skid.sv =====
module lps_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lps_pkg::t_result  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lps_pkg::t_result  o_data
);
    import lps_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main_data, n_main_data;
    t_result r_skid_data, n_skid_data;
    logic    push, pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main_data;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main_data  = r_main_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (pop) begin
                n_main_data  = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_main_valid || pop) begin
                n_main_data  = i_data;
                n_main_valid = 1'b1;
            end else begin
                // receiver stalled: park the result aside
                n_skid_data  = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main_data <= n_main_data;
        r_skid_data <= n_skid_data;
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("spare entry full with head empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (!r_skid_valid && r_main_valid
            && (r_main_data == $past(r_skid_data))))
        else $error("spare entry lost or reordered");

endmodule

// ===== rtl/core/led_pattern_sequencer.sv =====
// led pattern sequencer
// requests come in on the s_axis channel: tuser bit 0 selects a 100 ms tick (0)
// or a start request (1), tdata bit 0 carries the cancel button level.
// every accepted request yields exactly one result on m_axis: the led drive
// bits and a busy flag that stays high while a pattern runs or waits for release.
// the mode and led count are written through the cfg channel; the user must write them only
// while idle, the block itself does not enforce it; cfg_ready is always high.
// the state update is a single pass of logic behind the state registers, so one
// request is taken every cycle while s_axis_tready is high; each result is
// registered in the output buffer before it is driven on m_axis.
// a two-entry output buffer keeps s_axis_tready registered: when the receiver
// stalls, one more request is taken into the spare entry and s_axis_tready then
// drops until the receiver takes a result.
// synchronous reset clears the pattern state to idle with all leds dark, empties
// the output buffer and restores mode 0 and a count of 16; there is no clearing pass.
module led_pattern_sequencer #(
    parameter int MAX_LEDS = lps_pkg::LPS_MAX_LEDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] cancel
    input  logic [0:0]                          s_axis_tuser,   // [0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // [15:0] leds, [16] busy_res
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lps_pkg::LPS_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lps_pkg::LPS_CFG_DATA_W-1:0]  i_cfg_data
);
    import lps_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    lps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lps_core #(
        .MAX_LEDS (MAX_LEDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_req_type (s_axis_tuser[0]),
        .i_cancel   (s_axis_tdata[0]),
        .i_cfg      (cfg),
        .o_result   (core_result)
    );

    lps_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (core_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result.busy, out_result.leds};

endmodule

// ===== test/led_pattern_sequencer_tb.sv =====
`timescale 1ns / 1ps

module led_pattern_sequencer_tb;
    import lps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam logic [LPS_CFG_DATA_W-1:0] MODE_OUT_OF_RANGE = 5'd7;

    class led_pattern_tracker;
        logic [LPS_MODE_W-1:0]  mode_reg;
        logic [LPS_COUNT_W-1:0] count_reg;
        logic [LPS_LEDS_W-1:0]  led_bits;
        t_phase                 phase;
        logic [3:0]             position;
        logic [LPS_TICK_W-1:0]  tick_count;
        logic [LPS_STEP_W-1:0]  morse_step;
        logic                   parity;
        t_result                leds_due[$];
        int                     errors;

        function new();
            mode_reg  = LPS_MODE_RST;
            count_reg = LPS_COUNT_RST;
            led_bits  = '0;
            phase     = PH_IDLE;
            errors    = 0;
            clear_counters();
        endfunction

        function void clear_counters();
            position   = '0;
            tick_count = '0;
            morse_step = '0;
            parity     = 1'b0;
        endfunction

        function int pending();
            return leds_due.size();
        endfunction

        function void write_reg(logic [LPS_CFG_IDX_W-1:0] idx, logic [LPS_CFG_DATA_W-1:0] data);
            if (idx == LPS_CFG_MODE) mode_reg = data[LPS_MODE_W-1:0];
            else if (idx == LPS_CFG_COUNT) count_reg = data;
        endfunction

        function int live_count();
            return (count_reg > LPS_MAX_LEDS) ? LPS_MAX_LEDS : int'(count_reg);
        endfunction

        function logic [LPS_MODE_W-1:0] live_mode();
            return (mode_reg > LPS_MODE_BLINK) ? LPS_MODE_BLINK : mode_reg;
        endfunction

        function logic [LPS_LEDS_W-1:0] live_mask(int n);
            return LPS_LEDS_W'((32'd1 << n) - 1);
        endfunction

        function logic [LPS_LEDS_W-1:0] bit_at(int i);
            return (i < LPS_LEDS_W) ? (LPS_LEDS_W'(1) << i) : '0;
        endfunction

        function void begin_pattern();
            int n;
            logic [LPS_LEDS_W-1:0] m;
            n = live_count();
            m = live_mask(n);
            phase = PH_RUN;
            clear_counters();
            if (n == 0) return;
            case (live_mode())
                LPS_MODE_FILL: begin
                    led_bits ^= bit_at(0);
                end
                LPS_MODE_RUNNER: begin
                    led_bits |= bit_at(n - 1);
                    led_bits ^= bit_at(0);
                    led_bits ^= bit_at(n - 1);
                end
                LPS_MODE_ALT: begin
                    led_bits ^= 16'h5555 & m;
                    led_bits ^= m;
                    parity = 1'b1;
                end
                LPS_MODE_SOS: begin
                    led_bits |= m;
                end
                default: begin
                    led_bits ^= m;
                end
            endcase
        endfunction

        function void sos_tick(bit cancel, logic [LPS_LEDS_W-1:0] m);
            logic [LPS_ELEM_W-1:0] elem;
            logic [LPS_TICK_W-1:0] span;
            bit last;
            elem = morse_step[LPS_STEP_W-1:1];
            last = (elem >= LPS_ELEM_LAST);
            tick_count = tick_count + 1'b1;
            if (!morse_step[0]) begin
                // lit part of a dot or dash
                span = (elem >= LPS_ELEM_DASH_LO && elem <= LPS_ELEM_DASH_HI) ?
                       LPS_DASH_TICKS : LPS_DOT_TICKS;
                if (tick_count >= span) begin
                    if (cancel) begin
                        phase = PH_DRAIN;
                        return;
                    end
                    led_bits &= ~m;
                    morse_step = morse_step + 1'b1;
                    tick_count = '0;
                end
            end else begin
                span = last ? LPS_WORD_GAP :
                       ((elem == LPS_ELEM_CHAR_A || elem == LPS_ELEM_CHAR_B) ?
                        LPS_CHAR_GAP : LPS_ELEM_GAP);
                if (tick_count >= span) begin
                    tick_count = '0;
                    if (last) begin
                        if (cancel) begin
                            phase = PH_DRAIN;
                            return;
                        end
                        morse_step = '0;
                    end else begin
                        morse_step = morse_step + 1'b1;
                    end
                    led_bits |= m;
                    if (cancel) phase = PH_DRAIN;
                end
            end
        endfunction

        function void tick_pattern(bit cancel);
            int n;
            int nxt;
            logic [LPS_LEDS_W-1:0] m;
            logic [LPS_MODE_W-1:0] md;
            n  = live_count();
            m  = live_mask(n);
            md = live_mode();
            if ((n == 0 || md != LPS_MODE_SOS) && cancel) begin
                phase = PH_DRAIN;
                return;
            end
            if (n == 0) return;
            if (md == LPS_MODE_SOS) begin
                sos_tick(cancel, m);
                return;
            end
            tick_count = tick_count + 1'b1;
            if (md == LPS_MODE_FILL || md == LPS_MODE_RUNNER) begin
                if (tick_count < LPS_STEP_TICKS) return;
                tick_count = '0;
                nxt = int'(position) + 1;
                if (nxt >= n) position = '0;
                else position = nxt[3:0];
                led_bits ^= bit_at(position);
                if (md == LPS_MODE_RUNNER)
                    led_bits ^= bit_at((position == 0) ? n - 1 : int'(position) - 1);
            end else begin
                if (tick_count < LPS_SLOW_TICKS) return;
                tick_count = '0;
                led_bits ^= m;
                if (md == LPS_MODE_ALT) parity = ~parity;
            end
        endfunction

        function void note_request(bit start, bit cancel);
            t_result want;
            case (phase)
                PH_IDLE: begin
                    if (start) begin
                        if (cancel) phase = PH_ARM;
                        else begin_pattern();
                    end
                end
                PH_ARM: begin
                    if (!cancel) begin_pattern();
                end
                PH_RUN: begin
                    if (!start) tick_pattern(cancel);
                end
                default: begin
                    // release clears everything, the request is not acted on otherwise
                    if (!cancel) begin
                        led_bits = '0;
                        phase = PH_IDLE;
                        clear_counters();
                    end
                end
            endcase
            want.leds = led_bits;
            want.busy = (phase != PH_IDLE);
            leds_due = {leds_due, want};
        endfunction

        function void check_result(logic [23:0] word);
            t_result want;
            if (leds_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no request waiting: leds %h busy %b",
                             $realtime, word[15:0], word[16]);
                return;
            end
            want = leds_due.pop_front();
            if (word[15:0] !== want.leds || word[16] !== want.busy) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: expected leds %h busy %b, got leds %h busy %b",
                             $realtime, want.leds, want.busy, word[15:0], word[16]);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;    // [0] cancel
    logic [0:0]                s_axis_tuser = '0;    // [0] req_type
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [23:0]               m_axis_tdata;         // [15:0] leds, [16] busy_res
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [LPS_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [LPS_CFG_DATA_W-1:0] i_cfg_data = '0;

    led_pattern_tracker tracker = new();
    bit calm = 1'b1;
    int run_items = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    led_pattern_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(99) < 25) stall_left <= pick_gap();
        end
    end

    // accepted requests, results and register writes, plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(s_axis_tuser[0], s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_req(bit start, bit cancel, bit counted = 1'b1);
        int gap;
        gap = (!calm && $urandom_range(99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cancel};
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (counted) run_items++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [LPS_CFG_IDX_W-1:0] idx, logic [LPS_CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_random_cfg(logic [LPS_CFG_IDX_W-1:0] idx);
        int r;
        logic [LPS_CFG_DATA_W-1:0] v;
        r = $urandom_range(99);
        if (idx == LPS_CFG_MODE) begin
            v = LPS_CFG_DATA_W'($urandom_range(0, 4));
            if (r < 12) v = LPS_CFG_DATA_W'($urandom_range(5, 7));
            // bits above the mode field are dropped
            if ($urandom_range(9) == 0) v[4:3] = 2'($urandom_range(1, 3));
        end else begin
            if (r < 10)      v = '0;
            else if (r < 22) v = 5'd16;
            else if (r < 30) v = LPS_CFG_DATA_W'($urandom_range(17, 31));
            else if (r < 38) v = 5'd1;
            else             v = LPS_CFG_DATA_W'($urandom_range(2, 15));
        end
        write_cfg(idx, v);
    endtask

    task automatic play_run();
        int ticks;
        int guard;
        int r;
        int k;
        settle();
        calm = ($urandom_range(3) == 0);
        write_random_cfg(LPS_CFG_MODE);
        write_random_cfg(LPS_CFG_COUNT);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_req(1'b0, 1'($urandom_range(1)), 1'b0);
        if ($urandom_range(3) == 0) begin
            // start while cancel held, then release on a request of either kind
            send_req(1'b1, 1'b1);
            repeat ($urandom_range(0, 3)) send_req(1'($urandom_range(1)), 1'b1);
            send_req(1'($urandom_range(1)), 1'b0);
        end else begin
            send_req(1'b1, 1'b0);
        end
        ticks = ($urandom_range(3) == 0) ? $urandom_range(60, 140) : $urandom_range(4, 40);
        for (k = 0; k < ticks; k++) begin
            r = $urandom_range(199);
            if (r < 6) begin
                send_req(1'b1, 1'($urandom_range(1)), 1'b0);
            end else if (r < 8) begin
                // change the setup while the pattern keeps running
                settle();
                write_random_cfg($urandom_range(1) ? LPS_CFG_COUNT : LPS_CFG_MODE);
            end else if (r < 10) begin
                break;
            end else begin
                send_req(1'b0, 1'b0);
            end
        end
        // sos only heeds cancel at element ends
        guard = 0;
        while (tracker.phase != PH_DRAIN && guard < 40) begin
            send_req(1'b0, 1'b1);
            guard++;
        end
        repeat ($urandom_range(0, 3)) send_req(1'($urandom_range(1)), 1'b1);
        send_req(1'($urandom_range(1)), 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks while idle, arming under cancel, start while running, drain and release
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b1);
        send_req(1'b1, 1'b0);

        // mode beyond the last one and a count above the row size
        settle();
        write_cfg(LPS_CFG_MODE, MODE_OUT_OF_RANGE);
        write_cfg(LPS_CFG_COUNT, 5'd31);
        send_req(1'b1, 1'b0);
        repeat (5) send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);

        // zero count ends on the first cancel, even in sos
        settle();
        write_cfg(LPS_CFG_MODE, {2'b00, LPS_MODE_SOS});
        write_cfg(LPS_CFG_COUNT, 5'd0);
        send_req(1'b1, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b1, 1'b0);

        calm = 1'b0;
        run_items = 0;
        while (run_items < RANDOM_ITEMS) play_run();

        calm = 1'b1;
        settle();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
